// ----- rtl/core/fat_directory_entry_search_core_macros.svh -----
// Assertion helpers used by the checker of this block.
`ifndef FAT_DIRECTORY_ENTRY_SEARCH_CORE_MACROS_SVH
`define FAT_DIRECTORY_ENTRY_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, ignored while rst is high.
`define FDS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked during reset as well.
`define FDS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/fat_des_pkg.sv -----
package fat_des_pkg;

  localparam int BUFFER_BYTES = 65536;
  localparam int ENTRY_BYTES  = 32;

  localparam logic [7:0] MARK_FREE = 8'hE5;
  localparam logic [7:0] MARK_DOT  = 8'h2E;
  localparam logic [7:0] SPACE_CH  = 8'h20;
  localparam logic [7:0] ATTR_DIR  = 8'h10;
  localparam logic [7:0] ATTR_FILE = 8'h20;

  localparam int OFF_ATTR    = 'h0B;
  localparam int OFF_CLUS_HI = 'h14;
  localparam int OFF_CLUS_LO = 'h1A;
  localparam int OFF_SIZE    = 'h1C;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_DIR  = 2'd1;
  localparam logic [1:0] KIND_FILE = 2'd2;

  localparam logic [1:0] CFG_TARGET_LOW    = 2'd0;
  localparam logic [1:0] CFG_TARGET_HIGH   = 2'd1;
  localparam logic [1:0] CFG_TARGET_LENGTH = 2'd2;

endpackage

// ----- rtl/core/fat_des_if.sv -----
interface fat_des_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] dir_byte;
  logic       last_byte;

  modport source (output valid, dir_byte, last_byte, input ready);
  modport sink (input valid, dir_byte, last_byte, output ready);
endinterface

interface fat_des_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [1:0]  entry_kind;
  logic [31:0] start_cluster;
  logic [31:0] file_size;
  logic [15:0] match_offset;

  modport source (output valid, found, entry_kind, start_cluster, file_size, match_offset,
                  input ready);
  modport sink (input valid, found, entry_kind, start_cluster, file_size, match_offset,
                output ready);
endinterface

// ----- rtl/core/fat_directory_entry_search_core.sv -----
// FAT 8.3 directory entry lookup.
// dir_in carries the directory buffer one byte per request, last_byte set on
// the final byte. res_out returns exactly one result per buffer: on the byte
// that ends the search (match, zero first byte, or no room for another
// entry), else on the last_byte request as not found. Later bytes of the
// buffer are consumed without effect.
// The target name is loaded through cfg_write_en / cfg_index / cfg_data while
// the block is idle.
// Throughput: one byte per cycle, unless a second result is due while the
// result register is still held. The byte that produces a result passes the
// input register, then the entry decode and name compare into the result register.
// A result held by a stalled receiver does not block input; dir_in.ready
// drops only while a second result is already due behind it.
// Reset (rst, synchronous) clears the search state, the target registers
// and both valid flags; entry bytes are not cleared.
module fat_directory_entry_search_core (
  input  logic                clk,
  input  logic                rst,
  fat_des_in_if.sink          dir_in,
  fat_des_out_if.source       res_out,
  input  logic                cfg_write_en,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data
);

  logic [63:0] target_chars_low;
  logic [31:0] target_chars_high;
  logic [3:0]  target_length;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;

  logic [7:0]  entry_bytes [32];
  logic [4:0]  byte_in_entry;
  logic [15:0] entry_start;
  logic        search_done;

  logic        out_valid;
  logic        out_found;
  logic [1:0]  out_kind;
  logic [31:0] out_cluster;
  logic [31:0] out_size;
  logic [15:0] out_offset;

  logic [11:0][7:0] ent_head;
  logic [11:0][7:0] target_chars;
  logic        name_match;
  logic        active;
  logic        end_byte;
  logic        skip;
  logic        zero_mark;
  logic        hit;
  logic        out_of_room;
  logic        ended;
  logic        emit;
  logic        s1_go;
  logic [1:0]  kind;
  logic        res_found;
  logic [7:0]  attr;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_chars_low  <= '0;
      target_chars_high <= '0;
      target_length     <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        fat_des_pkg::CFG_TARGET_LOW:    target_chars_low  <= cfg_data;
        fat_des_pkg::CFG_TARGET_HIGH:   target_chars_high <= cfg_data[31:0];
        fat_des_pkg::CFG_TARGET_LENGTH: target_length     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign target_chars = {target_chars_high, target_chars_low};

  always_comb begin
    for (int j = 0; j < 12; j++) ent_head[j] = entry_bytes[j];
  end

  fat_des_name_match u_match (
    .ent_head      (ent_head),
    .target_chars  (target_chars),
    .target_length (target_length),
    .match         (name_match)
  );

  assign attr      = entry_bytes[fat_des_pkg::OFF_ATTR];
  assign active    = s1_valid && !search_done;
  assign end_byte  = byte_in_entry == 5'(fat_des_pkg::ENTRY_BYTES - 1);
  assign skip      = entry_bytes[0] == fat_des_pkg::MARK_FREE ||
                     entry_bytes[0] == fat_des_pkg::MARK_DOT;
  assign zero_mark = entry_bytes[0] == 8'h00;
  assign hit       = !skip && !zero_mark && name_match;
  assign out_of_room = ({2'b00, entry_start} + 18'(2 * fat_des_pkg::ENTRY_BYTES))
                       > 18'(fat_des_pkg::BUFFER_BYTES);
  assign ended     = end_byte && !skip && (zero_mark || name_match || out_of_room) ||
                     end_byte && skip && out_of_room;
  assign emit      = active && (ended || s1_last);

  always_comb begin
    if (attr == fat_des_pkg::ATTR_DIR)       kind = fat_des_pkg::KIND_DIR;
    else if (attr == fat_des_pkg::ATTR_FILE) kind = fat_des_pkg::KIND_FILE;
    else                                     kind = fat_des_pkg::KIND_NONE;
  end

  assign res_found = active && end_byte && hit && kind != fat_des_pkg::KIND_NONE;

  // the stage moves unless it owes a result and the result register is still held
  assign s1_go        = s1_valid && (!emit || !out_valid || res_out.ready);
  assign dir_in.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (dir_in.ready) begin
      s1_valid <= dir_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dir_in.valid && dir_in.ready) begin
      s1_byte <= dir_in.dir_byte;
      s1_last <= dir_in.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && !search_done) entry_bytes[byte_in_entry] <= s1_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_in_entry <= '0;
      entry_start   <= '0;
      search_done   <= 1'b0;
    end else if (s1_go) begin
      if (s1_last) begin
        byte_in_entry <= '0;
        entry_start   <= '0;
        search_done   <= 1'b0;
      end else if (!search_done) begin
        byte_in_entry <= byte_in_entry + 5'd1;
        if (end_byte) entry_start <= entry_start + 16'(fat_des_pkg::ENTRY_BYTES);
        if (ended) search_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && emit) begin
      out_valid <= 1'b1;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // byte 31 of the entry is the one in flight, so the size top byte comes from s1
  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      out_found <= res_found;
      if (res_found) begin
        out_kind    <= kind;
        out_cluster <= {entry_bytes[fat_des_pkg::OFF_CLUS_HI + 1],
                        entry_bytes[fat_des_pkg::OFF_CLUS_HI],
                        entry_bytes[fat_des_pkg::OFF_CLUS_LO + 1],
                        entry_bytes[fat_des_pkg::OFF_CLUS_LO]};
        out_size    <= {s1_byte,
                        entry_bytes[fat_des_pkg::OFF_SIZE + 2],
                        entry_bytes[fat_des_pkg::OFF_SIZE + 1],
                        entry_bytes[fat_des_pkg::OFF_SIZE]};
        out_offset  <= entry_start;
      end else begin
        out_kind    <= fat_des_pkg::KIND_NONE;
        out_cluster <= '0;
        out_size    <= '0;
        out_offset  <= '0;
      end
    end
  end

  assign res_out.valid         = out_valid;
  assign res_out.found         = out_found;
  assign res_out.entry_kind    = out_kind;
  assign res_out.start_cluster = out_cluster;
  assign res_out.file_size     = out_size;
  assign res_out.match_offset  = out_offset;

endmodule

// ----- rtl/core/fat_des_name_match.sv -----
module fat_des_name_match (
  input  logic [11:0][7:0] ent_head,
  input  logic [11:0][7:0] target_chars,
  input  logic [3:0]       target_length,
  output logic             match
);

  logic [3:0]      base_len;
  logic [3:0]      ext_len;
  logic [3:0]      name_len;
  logic [3:0]      ext_idx;
  logic [7:0]      ch;
  logic            is_dir;
  logic            chars_ok;
  logic [2:0][7:0] ext_bytes;

  assign ext_bytes = ent_head[10:8];

  always_comb begin
    base_len = 4'd8;
    for (int j = 7; j >= 0; j--) begin
      if (ent_head[j] == fat_des_pkg::SPACE_CH) base_len = 4'(j);
    end
    ext_len = 4'd3;
    for (int j = 2; j >= 0; j--) begin
      if (ext_bytes[j] == fat_des_pkg::SPACE_CH) ext_len = 4'(j);
    end
    is_dir   = (ent_head[fat_des_pkg::OFF_ATTR] & fat_des_pkg::ATTR_DIR) != 8'h00;
    name_len = is_dir ? base_len : base_len + 4'd1 + ext_len;

    // character k of the formed name: base, then dot, then extension
    chars_ok = 1'b1;
    ext_idx  = 4'd0;
    ch       = 8'h00;
    for (int k = 0; k < 12; k++) begin
      ext_idx = 4'(k) - base_len - 4'd1;
      if (4'(k) < base_len) begin
        ch = ent_head[k];
      end else if (4'(k) == base_len) begin
        ch = fat_des_pkg::MARK_DOT;
      end else if (ext_idx < 4'd3) begin
        ch = ext_bytes[ext_idx[1:0]];
      end else begin
        ch = 8'h00;
      end
      if (4'(k) < name_len && ch != target_chars[k]) chars_ok = 1'b0;
    end
    match = (name_len == target_length) && chars_ok;
  end

endmodule

// ----- rtl/core/fat_des_checker.sv -----
`include "fat_directory_entry_search_core_macros.svh"

module fat_des_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        found,
  input logic [1:0]  entry_kind,
  input logic [31:0] start_cluster,
  input logic [31:0] file_size,
  input logic [15:0] match_offset
);

  `FDS_ASSERT_NXT(a_reset_clears_out, rst, !out_valid, "result valid right after reset")

  `FDS_ASSERT_NXT(a_stall_holds, !rst && out_valid && !out_ready,
    out_valid && $stable({found, entry_kind, start_cluster, file_size, match_offset}),
    "result dropped or changed while stalled")

  `FDS_ASSERT_IMP(a_found_kind, out_valid && found,
    entry_kind == fat_des_pkg::KIND_DIR || entry_kind == fat_des_pkg::KIND_FILE,
    "found result with unknown kind")

  `FDS_ASSERT_IMP(a_miss_zero, out_valid && !found,
    entry_kind == fat_des_pkg::KIND_NONE && start_cluster == 32'd0 &&
    file_size == 32'd0 && match_offset == 16'd0,
    "not-found result carries nonzero fields")

  `FDS_ASSERT_IMP(a_offset_aligned, out_valid && found,
    match_offset[4:0] == 5'd0, "entry offset not on an entry boundary")

endmodule

bind fat_directory_entry_search_core fat_des_checker u_fat_des_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (res_out.valid),
  .out_ready     (res_out.ready),
  .found         (res_out.found),
  .entry_kind    (res_out.entry_kind),
  .start_cluster (res_out.start_cluster),
  .file_size     (res_out.file_size),
  .match_offset  (res_out.match_offset)
);

// ----- tb/tb_fat_directory_entry_search_core.sv -----
`timescale 1ns / 1ps

module tb_fat_directory_entry_search_core;

  localparam logic [7:0] END_MARK = 8'h00;

  typedef logic [31:0][7:0] entry_t;

  typedef struct packed {
    logic        found;
    logic [1:0]  kind;
    logic [31:0] cluster;
    logic [31:0] fsize;
    logic [15:0] offset;
  } lookup_t;

  logic clk = 1'b0;
  logic rst;
  logic        cfg_write_en;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  fat_des_in_if  dir_in();
  fat_des_out_if res_out();

  fat_directory_entry_search_core dut (
    .clk          (clk),
    .rst          (rst),
    .dir_in       (dir_in),
    .res_out      (res_out),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // scanner state as the block should hold it
  entry_t      entry_buf;
  logic [4:0]  fill_pos = '0;
  int unsigned entry_base = 0;
  bit          lookup_closed = 1'b0;
  logic [63:0] tgt_lo = '0;
  logic [31:0] tgt_hi = '0;
  logic [3:0]  tgt_len = '0;
  lookup_t     lookups_due[$];

  // current target as a name, for building matching entries
  logic [63:0] t_base;
  logic [23:0] t_ext;
  int          t_bl;
  int          t_el;
  bit          t_dir;

  logic [7:0] dir_image[$];
  int src_idle = 0;
  int sink_stall = 0;
  int hold_left = 0;
  int err_count = 0;
  int bytes_sent = 0;
  int buffers_sent = 0;
  int results_seen = 0;
  int hits_expected = 0;
  int cfg_writes = 0;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= 100)
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
  endtask

  // base cut at first space; dot and extension only when the dir bit is clear
  function automatic void form_name(input entry_t e, output logic [95:0] nm, output int n);
    nm = '0;
    n = 0;
    for (int j = 0; j < 8; j++) begin
      if (e[j] == fat_des_pkg::SPACE_CH) break;
      nm[8*n +: 8] = e[j];
      n++;
    end
    if ((e[fat_des_pkg::OFF_ATTR] & fat_des_pkg::ATTR_DIR) == 8'h00) begin
      nm[8*n +: 8] = fat_des_pkg::MARK_DOT;
      n++;
      for (int j = 8; j <= 10; j++) begin
        if (e[j] == fat_des_pkg::SPACE_CH) break;
        nm[8*n +: 8] = e[j];
        n++;
      end
    end
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic lb);
    logic [95:0] nm;
    logic [95:0] tc;
    logic [7:0]  attr;
    int          n;
    bit          ended;
    bit          hit;
    lookup_t     r;
    ended = 1'b0;
    r = '0;
    if (!lookup_closed) begin
      entry_buf[fill_pos] = b;
      if (fill_pos == 5'd31) begin
        if (entry_buf[0] == END_MARK) begin
          ended = 1'b1;
        end else if (entry_buf[0] != fat_des_pkg::MARK_FREE &&
                     entry_buf[0] != fat_des_pkg::MARK_DOT) begin
          form_name(entry_buf, nm, n);
          tc = {tgt_hi, tgt_lo};
          hit = (n == int'(tgt_len));
          for (int j = 0; j < n; j++)
            if (nm[8*j +: 8] != tc[8*j +: 8]) hit = 1'b0;
          if (hit) begin
            ended = 1'b1;
            attr = entry_buf[fat_des_pkg::OFF_ATTR];
            if (attr == fat_des_pkg::ATTR_DIR || attr == fat_des_pkg::ATTR_FILE) begin
              r.found = 1'b1;
              r.kind = (attr == fat_des_pkg::ATTR_DIR) ? fat_des_pkg::KIND_DIR
                                                       : fat_des_pkg::KIND_FILE;
              r.cluster = {entry_buf[fat_des_pkg::OFF_CLUS_HI+1],
                           entry_buf[fat_des_pkg::OFF_CLUS_HI],
                           entry_buf[fat_des_pkg::OFF_CLUS_LO+1],
                           entry_buf[fat_des_pkg::OFF_CLUS_LO]};
              r.fsize = {entry_buf[fat_des_pkg::OFF_SIZE+3], entry_buf[fat_des_pkg::OFF_SIZE+2],
                         entry_buf[fat_des_pkg::OFF_SIZE+1], entry_buf[fat_des_pkg::OFF_SIZE]};
              r.offset = entry_base[15:0];
            end
          end
        end
        if (!ended) begin
          // no room left for another full entry
          if (entry_base + 2 * fat_des_pkg::ENTRY_BYTES > fat_des_pkg::BUFFER_BYTES)
            ended = 1'b1;
          entry_base += fat_des_pkg::ENTRY_BYTES;
          fill_pos = '0;
        end
      end else begin
        fill_pos++;
      end
      if (ended || lb) begin
        lookup_closed = 1'b1;
        lookups_due.push_back(r);
        if (r.found) hits_expected++;
      end
    end
    if (lb) begin
      fill_pos = '0;
      entry_base = 0;
      lookup_closed = 1'b0;
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic lb);
    while ($urandom_range(99) < src_idle) begin
      dir_in.valid <= 1'b0;
      @(posedge clk);
    end
    dir_in.valid     <= 1'b1;
    dir_in.dir_byte  <= b;
    dir_in.last_byte <= lb;
    @(posedge clk);
    while (!dir_in.ready) @(posedge clk);
    predict_byte(b, lb);
    bytes_sent++;
  endtask

  task automatic stream_image();
    for (int i = 0; i < dir_image.size(); i++)
      send_byte(dir_image[i], i == dir_image.size() - 1);
    dir_image.delete();
    buffers_sent++;
  endtask

  // the block can still be busy after the last result is taken
  task automatic wait_drain();
    dir_in.valid <= 1'b0;
    while (lookups_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_target(input logic [95:0] chars, input logic [3:0] len);
    wait_drain();
    cfg_write_en <= 1'b1;
    cfg_index    <= fat_des_pkg::CFG_TARGET_LOW;
    cfg_data     <= chars[63:0];
    @(posedge clk);
    cfg_index    <= fat_des_pkg::CFG_TARGET_HIGH;
    cfg_data     <= {32'($urandom), chars[95:64]};
    @(posedge clk);
    cfg_index    <= fat_des_pkg::CFG_TARGET_LENGTH;
    cfg_data     <= {32'($urandom), 28'($urandom), len};
    @(posedge clk);
    cfg_write_en <= 1'b0;
    tgt_lo  = chars[63:0];
    tgt_hi  = chars[95:64];
    tgt_len = len;
    cfg_writes += 3;
  endtask

  function automatic logic [63:0] rand_chars(input int n, input bit lead);
    logic [63:0] c;
    logic [7:0]  ch;
    c = '0;
    for (int i = 0; i < n; i++) begin
      do ch = 8'($urandom);
      while (ch == fat_des_pkg::SPACE_CH ||
             (lead && i == 0 && (ch == END_MARK || ch == fat_des_pkg::MARK_FREE ||
                                 ch == fat_des_pkg::MARK_DOT)));
      c[8*i +: 8] = ch;
    end
    return c;
  endfunction

  // space after the name, junk after the space
  function automatic logic [63:0] name_field(input logic [63:0] chars, input int n,
                                             input int w);
    logic [63:0] f;
    f = chars;
    for (int i = n; i < w; i++)
      f[8*i +: 8] = (i == n) ? fat_des_pkg::SPACE_CH : 8'($urandom);
    return f;
  endfunction

  function automatic entry_t make_entry(input logic [63:0] base, input logic [23:0] ext,
                                        input logic [7:0] attr, input logic [31:0] clus,
                                        input logic [31:0] fsize);
    entry_t e;
    for (int i = 0; i < 32; i++) e[i] = 8'($urandom);
    for (int i = 0; i < 8; i++) e[i] = base[8*i +: 8];
    for (int i = 0; i < 3; i++) e[8+i] = ext[8*i +: 8];
    e[fat_des_pkg::OFF_ATTR]      = attr;
    e[fat_des_pkg::OFF_CLUS_HI]   = clus[23:16];
    e[fat_des_pkg::OFF_CLUS_HI+1] = clus[31:24];
    e[fat_des_pkg::OFF_CLUS_LO]   = clus[7:0];
    e[fat_des_pkg::OFF_CLUS_LO+1] = clus[15:8];
    for (int i = 0; i < 4; i++) e[fat_des_pkg::OFF_SIZE+i] = fsize[8*i +: 8];
    return e;
  endfunction

  function automatic entry_t random_entry();
    int bl;
    int el;
    bl = $urandom_range(8, 1);
    el = $urandom_range(3, 0);
    return make_entry(name_field(rand_chars(bl, 1'b1), bl, 8),
                      24'(name_field(rand_chars(el, 1'b0), el, 3)),
                      8'($urandom), $urandom, $urandom);
  endfunction

  function automatic entry_t marked_entry(input logic [7:0] mark);
    entry_t e;
    e = random_entry();
    e[0] = mark;
    return e;
  endfunction

  function automatic entry_t raw_entry();
    entry_t e;
    for (int i = 0; i < 32; i++) e[i] = 8'($urandom);
    return e;
  endfunction

  function automatic entry_t target_entry(input logic [7:0] attr, input logic [31:0] clus,
                                          input logic [31:0] fsize);
    return make_entry(name_field(t_base, t_bl, 8), 24'(name_field({40'h0, t_ext}, t_el, 3)),
                      attr, clus, fsize);
  endfunction

  // mostly a proper kind, else an attribute of unknown kind with the same name form
  function automatic logic [7:0] match_attr();
    logic [7:0] a;
    a = 8'($urandom);
    if ($urandom_range(3) != 0) return t_dir ? fat_des_pkg::ATTR_DIR : fat_des_pkg::ATTR_FILE;
    return t_dir ? (a | fat_des_pkg::ATTR_DIR) : (a & ~fat_des_pkg::ATTR_DIR);
  endfunction

  task automatic push_entry(input entry_t e, input int nbytes);
    for (int i = 0; i < nbytes; i++) dir_image.push_back(e[i]);
  endtask

  task automatic choose_target(input int bl, input int el, input bit dir);
    entry_t      e;
    logic [95:0] nm;
    int          n;
    t_bl   = bl;
    t_el   = el;
    t_dir  = dir;
    t_base = rand_chars(bl, 1'b1);
    t_ext  = 24'(rand_chars(el, 1'b0));
    e = target_entry(dir ? fat_des_pkg::ATTR_DIR : fat_des_pkg::ATTR_FILE, '0, '0);
    form_name(e, nm, n);
    set_target(nm, 4'(n));
  endtask

  task automatic random_buffer();
    int     n_ent;
    entry_t e;
    n_ent = $urandom_range(3, 0);
    for (int i = 0; i < n_ent; i++) begin
      case ($urandom_range(11))
        0, 1, 2: e = random_entry();
        3:       e = marked_entry(fat_des_pkg::MARK_FREE);
        4:       e = marked_entry(fat_des_pkg::MARK_DOT);
        5:       e = marked_entry(END_MARK);
        6:       e = raw_entry();
        default: e = target_entry(match_attr(), $urandom, $urandom);
      endcase
      push_entry(e, 32);
    end
    // partial entry at the tail, often a prefix of a matching one
    if (dir_image.size() == 0 || $urandom_range(3) == 0) begin
      e = $urandom_range(1) ? target_entry(match_attr(), $urandom, $urandom) : raw_entry();
      push_entry(e, $urandom_range(31, 1));
    end
    stream_image();
  endtask

  task automatic test_reset_target();
    push_entry(random_entry(), 32);
    stream_image();
    dir_image.push_back(8'hFF);
    stream_image();
  endtask

  task automatic test_match_cases();
    src_idle = 0;
    sink_stall = 0;
    choose_target(8, 3, 1'b0);
    // full twelve-character name, all-ones fields, trailing bytes ignored
    push_entry(target_entry(fat_des_pkg::ATTR_FILE, '1, '1), 32);
    repeat (5) dir_image.push_back(8'hFF);
    stream_image();
    push_entry(marked_entry(fat_des_pkg::MARK_FREE), 32);
    push_entry(marked_entry(fat_des_pkg::MARK_DOT), 32);
    push_entry(random_entry(), 32);
    push_entry(target_entry(fat_des_pkg::ATTR_FILE, '0, '0), 32);
    stream_image();
    // unknown kind still ends the search
    push_entry(target_entry(fat_des_pkg::ATTR_FILE | 8'h01, $urandom, $urandom), 32);
    push_entry(target_entry(fat_des_pkg::ATTR_FILE, $urandom, $urandom), 32);
    stream_image();
    push_entry(marked_entry(END_MARK), 32);
    push_entry(target_entry(fat_des_pkg::ATTR_FILE, $urandom, $urandom), 32);
    stream_image();
    push_entry(target_entry(fat_des_pkg::ATTR_FILE, $urandom, $urandom), 20);
    stream_image();
  endtask

  task automatic test_dir_and_length();
    choose_target(1, 3, 1'b1);
    // same base as a file gets a dot and extension, so no hit
    push_entry(target_entry(fat_des_pkg::ATTR_FILE, $urandom, $urandom), 32);
    push_entry(target_entry(fat_des_pkg::ATTR_DIR, $urandom, $urandom), 32);
    stream_image();
    set_target('1, 4'd15);
    push_entry(random_entry(), 32);
    push_entry(target_entry(fat_des_pkg::ATTR_DIR, $urandom, $urandom), 32);
    stream_image();
  endtask

  task automatic test_backpressure();
    src_idle = 0;
    sink_stall = 0;
    choose_target(4, 2, 1'b0);
    hold_left = 300;
    for (int i = 0; i < 12; i++) begin
      if (i % 2 == 1) push_entry(target_entry(fat_des_pkg::ATTR_FILE, $urandom, $urandom), 32);
      else dir_image.push_back(8'($urandom));
      stream_image();
    end
    wait_drain();
    repeat (3) random_buffer();
  endtask

  task automatic test_random_mix(input int src, input int sink, input int budget);
    int start;
    src_idle = src;
    sink_stall = sink;
    choose_target($urandom_range(8, 1), $urandom_range(3, 0), $urandom_range(1));
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      if ($urandom_range(7) == 0)
        choose_target($urandom_range(8, 1), $urandom_range(3, 0), $urandom_range(1));
      random_buffer();
    end
  endtask

  // receiver: random stalls, or a counted long hold-off
  initial begin
    res_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        res_out.ready <= 1'b0;
        hold_left--;
      end else begin
        res_out.ready <= !rst && ($urandom_range(99) >= sink_stall);
      end
    end
  end

  always @(posedge clk) begin : check_lookups
    lookup_t want;
    if (!rst && res_out.valid && res_out.ready) begin
      if (lookups_due.size() == 0) begin
        report_mismatch("result with none pending", '0, '0);
      end else begin
        want = lookups_due.pop_front();
        results_seen++;
        if (res_out.found !== want.found)
          report_mismatch("found", 32'(res_out.found), 32'(want.found));
        if (res_out.entry_kind !== want.kind)
          report_mismatch("entry_kind", 32'(res_out.entry_kind), 32'(want.kind));
        if (res_out.start_cluster !== want.cluster)
          report_mismatch("start_cluster", res_out.start_cluster, want.cluster);
        if (res_out.file_size !== want.fsize)
          report_mismatch("file_size", res_out.file_size, want.fsize);
        if (res_out.match_offset !== want.offset)
          report_mismatch("match_offset", 32'(res_out.match_offset), 32'(want.offset));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("timeout: %0d lookup results still outstanding", lookups_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst              <= 1'b1;
    dir_in.valid     <= 1'b0;
    dir_in.dir_byte  <= '0;
    dir_in.last_byte <= 1'b0;
    cfg_write_en     <= 1'b0;
    cfg_index        <= fat_des_pkg::CFG_TARGET_LOW;
    cfg_data         <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_target();
    test_match_cases();
    test_dir_and_length();
    test_backpressure();
    test_random_mix(0, 0, 260);
    test_random_mix(80, 0, 260);
    test_random_mix(0, 80, 260);
    test_random_mix(13, 13, 260);

    wait_drain();
    repeat (10) @(posedge clk);
    $display("%0d directory buffers, %0d bytes, %0d lookups checked (%0d hits), %0d reg writes",
             buffers_sent, bytes_sent, results_seen, hits_expected, cfg_writes);
    $display("covered skip/end markers, unknown kinds, partial tails, long hold-off, stalls");
    if (err_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
